@@ design/nfbta_pkg.sv @@
// Shared types, codes and constants for the next-fit boundary-tag allocator.
// Used by the controller and the top level; no dependencies.
package nfbta_pkg;

  // sizes of the request and result fields
  localparam int FUNC_W = 2;
  localparam int REQ_W = 21;
  localparam int ADDR_W = 20;
  localparam int STAT_W = 2;

  // heap geometry
  localparam int HEAP_BYTES_DEF = 1048576;
  localparam int TAG_W = 64;
  localparam int GROW_MIN = 1 << 12;
  localparam int MIN_BLOCK = 32;
  localparam int ALIGN = 16;

  // command codes
  localparam logic [FUNC_W-1:0] FN_MALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REALLOC = 2'd2;
  localparam logic [FUNC_W-1:0] FN_INIT = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OOM = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOINIT = 2'd3;

  // sequencer states
  localparam int ST_W = 39;
  typedef enum logic [ST_W-1:0] {
    S_IDLE = 39'd1 << 0,
    S_CMD  = 39'd1 << 1,
    S_I0   = 39'd1 << 2,
    S_I1   = 39'd1 << 3,
    S_I2   = 39'd1 << 4,
    S_I3   = 39'd1 << 5,
    S_I4   = 39'd1 << 6,
    S_V0   = 39'd1 << 7,
    S_V1   = 39'd1 << 8,
    S_V2   = 39'd1 << 9,
    S_X0   = 39'd1 << 10,
    S_X1   = 39'd1 << 11,
    S_X2   = 39'd1 << 12,
    S_X3   = 39'd1 << 13,
    S_X4   = 39'd1 << 14,
    S_XOK  = 39'd1 << 15,
    S_X5   = 39'd1 << 16,
    S_M0   = 39'd1 << 17,
    S_M1   = 39'd1 << 18,
    S_MOK  = 39'd1 << 19,
    S_F0   = 39'd1 << 20,
    S_F1   = 39'd1 << 21,
    S_P0   = 39'd1 << 22,
    S_P1   = 39'd1 << 23,
    S_P2   = 39'd1 << 24,
    S_G0   = 39'd1 << 25,
    S_G1   = 39'd1 << 26,
    S_C0   = 39'd1 << 27,
    S_C1   = 39'd1 << 28,
    S_C2   = 39'd1 << 29,
    S_C3   = 39'd1 << 30,
    S_C4   = 39'd1 << 31,
    S_R0   = 39'd1 << 32,
    S_R1   = 39'd1 << 33,
    S_R2   = 39'd1 << 34,
    S_R3   = 39'd1 << 35,
    S_SB0  = 39'd1 << 36,
    S_SB1  = 39'd1 << 37,
    S_OUT  = 39'd1 << 38
  } nfbta_state_t;

  // finished result handed from the controller to the output register
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] result_addr;
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] copy_from;
    logic [REQ_W-1:0]  copy_bytes;
  } nfbta_res_t;

endpackage

@@ design/nfbta_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module nfbta_ram #(
  parameter int DATA_W = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/nfbta_ctrl.sv @@
// Command sequencer: walks and rewrites boundary tags through the tag RAM.
// Depends on nfbta_pkg; drives the ports of one nfbta_ram.
module nfbta_ctrl #(
  parameter int HEAP_BYTES = nfbta_pkg::HEAP_BYTES_DEF,
  parameter int IW = $clog2(HEAP_BYTES / 8)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [nfbta_pkg::FUNC_W-1:0] in_func,
  input  logic [nfbta_pkg::REQ_W-1:0]  in_req_bytes,
  input  logic [nfbta_pkg::ADDR_W-1:0] in_block_addr,
  output nfbta_pkg::nfbta_res_t      res,
  input  logic                       res_ack,
  output logic                       ram_we,
  output logic [IW-1:0]              ram_waddr,
  output logic [nfbta_pkg::TAG_W-1:0]  ram_wdata,
  output logic                       ram_re,
  output logic [IW-1:0]              ram_raddr,
  input  logic [nfbta_pkg::TAG_W-1:0]  ram_rdata
);
  import nfbta_pkg::*;

  localparam int AW = $clog2(HEAP_BYTES + 1);
  localparam int SW = ((AW > 23) ? AW : 23) + 1;

  // byte offset to tag word index
  function automatic logic [IW-1:0] widx(input logic [SW-1:0] off);
    widx = off[IW+2:3];
  endfunction

  // size field of a tag word
  function automatic logic [SW-1:0] tsz(input logic [TAG_W-1:0] w);
    tsz = {w[SW-1:4], 4'b0000};
  endfunction

  // tag word from size and allocated bit
  function automatic logic [TAG_W-1:0] tag(input logic [SW-1:0] sz, input logic a);
    tag = TAG_W'({sz[SW-1:1], a});
  endfunction

  function automatic logic [SW-1:0] align16(input logic [SW-1:0] x);
    align16 = (x + SW'(ALIGN - 1)) & ~SW'(ALIGN - 1);
  endfunction

  // block size for a request: payload plus tags, 16-aligned, at least the minimum
  function automatic logic [SW-1:0] adjust(input logic [REQ_W-1:0] rq);
    logic [SW-1:0] a;
    a = align16(SW'(rq) + SW'(ALIGN));
    adjust = (a < SW'(MIN_BLOCK)) ? SW'(MIN_BLOCK) : a;
  endfunction

  nfbta_state_t state_r, state_nxt;
  nfbta_state_t ret_sb_r, ret_sb_nxt, ret_coal_r, ret_coal_nxt, ret_grow_r, ret_grow_nxt;
  nfbta_state_t ret_place_r, ret_place_nxt, ret_malloc_r, ret_malloc_nxt;
  nfbta_state_t ret_free_r, ret_free_nxt;
  logic [SW-1:0] hb_r, hb_nxt, rover_r, rover_nxt, first_r, first_nxt;
  logic          ready_r, ready_nxt;

  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [SW-1:0] ptr_r, ptr_nxt, bp_r, bp_nxt, start_r, start_nxt;
  logic          phase_r, phase_nxt;
  logic [SW-1:0] asize_r, asize_nxt, oldsize_r, oldsize_nxt, next_r, next_nxt;
  logic [SW-1:0] total_r, total_nxt, csize_r, csize_nxt;
  logic [TAG_W-1:0] hdr_r, hdr_nxt;
  logic [SW-1:0] cbp_r, cbp_nxt, csz_r, csz_nxt, psz_r, psz_nxt, nsz_r, nsz_nxt;
  logic          pa_r, pa_nxt, na_r, na_nxt;
  logic [SW-1:0] gsz_r, gsz_nxt, gbp_r, gbp_nxt, pbp_r, pbp_nxt;
  logic [SW-1:0] sbp_r, sbp_nxt, ssz_r, ssz_nxt;
  logic          sa_r, sa_nxt;
  logic [SW-1:0] res_r, res_nxt, cfrom_r, cfrom_nxt, cbytes_r, cbytes_nxt;
  logic [STAT_W-1:0] st_r, st_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign res.valid = (state_r == S_OUT);
  assign res.result_addr = res_r[ADDR_W-1:0];
  assign res.status = st_r;
  assign res.copy_from = cfrom_r[ADDR_W-1:0];
  assign res.copy_bytes = cbytes_r[REQ_W-1:0];

  // sequencer; states that write never read, so no read sees a write in flight
  always_comb begin
    logic [SW-1:0] s, t, need;
    logic bad, miss, cond;
    s = '0; t = '0; need = '0; bad = 1'b0; miss = 1'b0; cond = 1'b0;
    state_nxt = state_r;
    ret_sb_nxt = ret_sb_r; ret_coal_nxt = ret_coal_r; ret_grow_nxt = ret_grow_r;
    ret_place_nxt = ret_place_r; ret_malloc_nxt = ret_malloc_r; ret_free_nxt = ret_free_r;
    hb_nxt = hb_r; rover_nxt = rover_r; first_nxt = first_r; ready_nxt = ready_r;
    func_nxt = func_r; req_nxt = req_r; ptr_nxt = ptr_r; bp_nxt = bp_r;
    start_nxt = start_r; phase_nxt = phase_r; asize_nxt = asize_r;
    oldsize_nxt = oldsize_r; next_nxt = next_r; total_nxt = total_r;
    csize_nxt = csize_r; hdr_nxt = hdr_r; cbp_nxt = cbp_r; csz_nxt = csz_r;
    psz_nxt = psz_r; nsz_nxt = nsz_r; pa_nxt = pa_r; na_nxt = na_r;
    gsz_nxt = gsz_r; gbp_nxt = gbp_r; pbp_nxt = pbp_r;
    sbp_nxt = sbp_r; ssz_nxt = ssz_r; sa_nxt = sa_r;
    res_nxt = res_r; cfrom_nxt = cfrom_r; cbytes_nxt = cbytes_r; st_nxt = st_r;
    ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0; ram_re = 1'b0; ram_raddr = '0;

    case (state_r)
      // take a request
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func;
          req_nxt = in_req_bytes;
          ptr_nxt = SW'(in_block_addr);
          res_nxt = '0; cfrom_nxt = '0; cbytes_nxt = '0; st_nxt = STAT_OK;
          state_nxt = S_CMD;
        end
      end
      // dispatch
      S_CMD: begin
        if (func_r == FN_INIT) begin
          state_nxt = S_I0;
        end else if (!ready_r) begin
          st_nxt = STAT_NOINIT;
          state_nxt = S_OUT;
        end else if (func_r == FN_MALLOC || (func_r == FN_REALLOC && ptr_r == '0)) begin
          ret_malloc_nxt = S_OUT;
          state_nxt = S_M0;
        end else if (ptr_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_V0;
        end
      end
      // init: pad, prologue, epilogue, then first growth
      S_I0: begin
        ram_we = 1'b1; ram_waddr = widx(SW'(0)); ram_wdata = '0;
        state_nxt = S_I1;
      end
      S_I1: begin
        ram_we = 1'b1; ram_waddr = widx(SW'(8)); ram_wdata = tag(SW'(ALIGN), 1'b1);
        state_nxt = S_I2;
      end
      S_I2: begin
        ram_we = 1'b1; ram_waddr = widx(SW'(16)); ram_wdata = tag(SW'(ALIGN), 1'b1);
        state_nxt = S_I3;
      end
      S_I3: begin
        ram_we = 1'b1; ram_waddr = widx(SW'(24)); ram_wdata = tag('0, 1'b1);
        hb_nxt = SW'(32); first_nxt = SW'(16); rover_nxt = SW'(16);
        gsz_nxt = SW'(GROW_MIN);
        ret_grow_nxt = S_I4;
        state_nxt = S_G0;
      end
      S_I4: begin
        ready_nxt = (cbp_r != '0);
        st_nxt = (cbp_r != '0) ? STAT_OK : STAT_OOM;
        state_nxt = S_OUT;
      end
      // block address checks
      S_V0: begin
        if (ptr_r[3:0] != 4'd0 || ptr_r < SW'(MIN_BLOCK) || ptr_r >= hb_r) begin
          bad = 1'b1;
        end else begin
          ram_re = 1'b1; ram_raddr = widx(ptr_r - SW'(8));
          state_nxt = S_V1;
        end
      end
      S_V1: begin
        s = tsz(ram_rdata);
        hdr_nxt = ram_rdata;
        oldsize_nxt = s;
        if (!ram_rdata[0] || s < SW'(MIN_BLOCK) || ptr_r + s > hb_r) begin
          bad = 1'b1;
        end else begin
          ram_re = 1'b1; ram_raddr = widx(ptr_r + s - SW'(16));
          state_nxt = S_V2;
        end
      end
      S_V2: begin
        if (ram_rdata != hdr_r) begin
          bad = 1'b1;
        end else if (func_r == FN_FREE) begin
          ret_free_nxt = S_OUT;
          state_nxt = S_R0;
        end else if (req_r == '0) begin
          st_nxt = STAT_NULL;
          ret_free_nxt = S_OUT;
          state_nxt = S_R0;
        end else begin
          state_nxt = S_X0;
        end
      end
      // realloc: look at the successor
      S_X0: begin
        asize_nxt = adjust(req_r);
        next_nxt = ptr_r + oldsize_r;
        ram_re = 1'b1; ram_raddr = widx(ptr_r + oldsize_r - SW'(8));
        state_nxt = S_X1;
      end
      S_X1: begin
        s = tsz(ram_rdata);
        if (asize_r <= oldsize_r) begin
          if (oldsize_r - asize_r >= SW'(MIN_BLOCK)) begin
            pbp_nxt = ptr_r; ret_place_nxt = S_XOK; state_nxt = S_P0;
          end else begin
            state_nxt = S_XOK;
          end
        end else if (!ram_rdata[0]) begin
          t = oldsize_r + s;
          if (t >= asize_r) begin
            // absorbed block was the rover: rover follows to the grown block
            if (rover_r == next_r) begin
              rover_nxt = ptr_r;
            end
            total_nxt = t;
            sbp_nxt = ptr_r; ssz_nxt = t; sa_nxt = 1'b1;
            ret_sb_nxt = S_X2; state_nxt = S_SB0;
          end else begin
            ret_malloc_nxt = S_X5; state_nxt = S_M0;
          end
        end else if (s == '0) begin
          need = asize_r - oldsize_r;
          gsz_nxt = (need > SW'(GROW_MIN)) ? need : SW'(GROW_MIN);
          ret_grow_nxt = S_X3; state_nxt = S_G0;
        end else begin
          ret_malloc_nxt = S_X5; state_nxt = S_M0;
        end
      end
      S_X2: begin
        if (total_r - asize_r >= SW'(MIN_BLOCK)) begin
          pbp_nxt = ptr_r; ret_place_nxt = S_XOK; state_nxt = S_P0;
        end else begin
          state_nxt = S_XOK;
        end
      end
      S_X3: begin
        if (cbp_r == next_r) begin
          ram_re = 1'b1; ram_raddr = widx(next_r - SW'(8));
          state_nxt = S_X4;
        end else begin
          ret_malloc_nxt = S_X5; state_nxt = S_M0;
        end
      end
      S_X4: begin
        t = oldsize_r + tsz(ram_rdata);
        total_nxt = t;
        sbp_nxt = ptr_r; ssz_nxt = t; sa_nxt = 1'b1;
        ret_sb_nxt = S_X2; state_nxt = S_SB0;
      end
      S_XOK: begin
        res_nxt = ptr_r; st_nxt = STAT_OK;
        state_nxt = S_OUT;
      end
      // realloc fallback: when the new block was found, report the copy and free the old block
      S_X5: begin
        if (res_r != '0) begin
          t = oldsize_r - SW'(16);
          cfrom_nxt = ptr_r;
          cbytes_nxt = (SW'(req_r) < t) ? SW'(req_r) : t;
          ret_free_nxt = S_OUT;
          state_nxt = S_R0;
        end else begin
          state_nxt = S_OUT;
        end
      end
      // malloc entry
      S_M0: begin
        if (req_r == '0) begin
          res_nxt = '0; st_nxt = STAT_NULL;
          state_nxt = ret_malloc_r;
        end else begin
          asize_nxt = adjust(req_r);
          bp_nxt = rover_r; start_nxt = rover_r; phase_nxt = 1'b0;
          state_nxt = S_F0;
        end
      end
      S_M1: begin
        if (cbp_r == '0) begin
          res_nxt = '0; st_nxt = STAT_OOM;
          state_nxt = ret_malloc_r;
        end else begin
          pbp_nxt = cbp_r; ret_place_nxt = S_MOK; state_nxt = S_P0;
        end
      end
      S_MOK: begin
        res_nxt = pbp_r; st_nxt = STAT_OK;
        state_nxt = ret_malloc_r;
      end
      // next-fit walk, one header read per block
      S_F0: begin
        cond = phase_r ? (bp_r < start_r && bp_r < hb_r) : (bp_r < hb_r);
        if (cond) begin
          ram_re = 1'b1; ram_raddr = widx(bp_r - SW'(8));
          state_nxt = S_F1;
        end else begin
          miss = 1'b1;
        end
      end
      S_F1: begin
        s = tsz(ram_rdata);
        if (s == '0) begin
          miss = 1'b1;
        end else if (!ram_rdata[0] && s >= asize_r) begin
          rover_nxt = bp_r;
          pbp_nxt = bp_r; ret_place_nxt = S_MOK; state_nxt = S_P0;
        end else begin
          bp_nxt = bp_r + s;
          state_nxt = S_F0;
        end
      end
      // place with optional split
      S_P0: begin
        ram_re = 1'b1; ram_raddr = widx(pbp_r - SW'(8));
        state_nxt = S_P1;
      end
      S_P1: begin
        s = tsz(ram_rdata);
        csize_nxt = s;
        sbp_nxt = pbp_r; sa_nxt = 1'b1;
        if (s >= asize_r + SW'(MIN_BLOCK)) begin
          ssz_nxt = asize_r; ret_sb_nxt = S_P2;
        end else begin
          ssz_nxt = s; ret_sb_nxt = ret_place_r;
        end
        state_nxt = S_SB0;
      end
      S_P2: begin
        sbp_nxt = pbp_r + asize_r; ssz_nxt = csize_r - asize_r; sa_nxt = 1'b0;
        ret_sb_nxt = ret_place_r; state_nxt = S_SB0;
      end
      // heap growth
      S_G0: begin
        s = align16(gsz_r);
        if (hb_r + s > SW'(HEAP_BYTES)) begin
          cbp_nxt = '0;
          state_nxt = ret_grow_r;
        end else begin
          gbp_nxt = hb_r; gsz_nxt = s; hb_nxt = hb_r + s;
          sbp_nxt = hb_r; ssz_nxt = s; sa_nxt = 1'b0;
          ret_sb_nxt = S_G1; state_nxt = S_SB0;
        end
      end
      S_G1: begin
        ram_we = 1'b1; ram_waddr = widx(gbp_r + gsz_r - SW'(8)); ram_wdata = tag('0, 1'b1);
        cbp_nxt = gbp_r; ret_coal_nxt = ret_grow_r; state_nxt = S_C0;
      end
      // coalesce: own header, previous footer, next header
      S_C0: begin
        ram_re = 1'b1; ram_raddr = widx(cbp_r - SW'(8));
        state_nxt = S_C1;
      end
      S_C1: begin
        s = tsz(ram_rdata);
        csz_nxt = s;
        ram_re = 1'b1; ram_raddr = widx(cbp_r - SW'(16));
        state_nxt = S_C2;
      end
      S_C2: begin
        pa_nxt = ram_rdata[0]; psz_nxt = tsz(ram_rdata);
        ram_re = 1'b1; ram_raddr = widx(cbp_r + csz_r - SW'(8));
        state_nxt = S_C3;
      end
      S_C3: begin
        s = tsz(ram_rdata);
        na_nxt = ram_rdata[0]; nsz_nxt = s;
        if (pa_r && ram_rdata[0]) begin
          state_nxt = ret_coal_r;
        end else if (pa_r) begin
          sbp_nxt = cbp_r; ssz_nxt = csz_r + s; sa_nxt = 1'b0;
          ret_sb_nxt = ret_coal_r; state_nxt = S_SB0;
        end else begin
          cbp_nxt = cbp_r - psz_r;
          ram_re = 1'b1; ram_raddr = widx(cbp_r - psz_r - SW'(8));
          state_nxt = S_C4;
        end
      end
      S_C4: begin
        t = csz_r + tsz(ram_rdata) + (na_r ? '0 : nsz_r);
        sbp_nxt = cbp_r; ssz_nxt = t; sa_nxt = 1'b0;
        ret_sb_nxt = ret_coal_r; state_nxt = S_SB0;
      end
      // free: clear the alloc bit, then coalesce and park the rover
      S_R0: begin
        ram_re = 1'b1; ram_raddr = widx(ptr_r - SW'(8));
        state_nxt = S_R1;
      end
      S_R1: begin
        sbp_nxt = ptr_r; ssz_nxt = tsz(ram_rdata); sa_nxt = 1'b0;
        ret_sb_nxt = S_R2; state_nxt = S_SB0;
      end
      S_R2: begin
        cbp_nxt = ptr_r; ret_coal_nxt = S_R3; state_nxt = S_C0;
      end
      S_R3: begin
        rover_nxt = cbp_r;
        state_nxt = ret_free_r;
      end
      // header then footer
      S_SB0: begin
        ram_we = 1'b1; ram_waddr = widx(sbp_r - SW'(8)); ram_wdata = tag(ssz_r, sa_r);
        state_nxt = S_SB1;
      end
      S_SB1: begin
        ram_we = 1'b1; ram_waddr = widx(sbp_r + ssz_r - SW'(16));
        ram_wdata = tag(ssz_r, sa_r);
        state_nxt = ret_sb_r;
      end
      // hand off the result
      S_OUT: begin
        if (res_ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a walk that runs out wraps once, then grows the heap
    if (miss) begin
      if (!phase_r) begin
        phase_nxt = 1'b1; bp_nxt = first_r; state_nxt = S_F0;
      end else begin
        gsz_nxt = (asize_r > SW'(GROW_MIN)) ? asize_r : SW'(GROW_MIN);
        ret_grow_nxt = S_M1; state_nxt = S_G0;
      end
    end

    // rejected block address
    if (bad) begin
      st_nxt = (func_r == FN_FREE) ? STAT_OK : STAT_OOM;
      state_nxt = S_OUT;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hb_r <= '0;
      rover_r <= '0;
      first_r <= '0;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hb_r <= hb_nxt;
      rover_r <= rover_nxt;
      first_r <= first_nxt;
      ready_r <= ready_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    ret_sb_r <= ret_sb_nxt; ret_coal_r <= ret_coal_nxt; ret_grow_r <= ret_grow_nxt;
    ret_place_r <= ret_place_nxt; ret_malloc_r <= ret_malloc_nxt; ret_free_r <= ret_free_nxt;
    func_r <= func_nxt; req_r <= req_nxt; ptr_r <= ptr_nxt; bp_r <= bp_nxt;
    start_r <= start_nxt; phase_r <= phase_nxt; asize_r <= asize_nxt;
    oldsize_r <= oldsize_nxt; next_r <= next_nxt; total_r <= total_nxt;
    csize_r <= csize_nxt; hdr_r <= hdr_nxt; cbp_r <= cbp_nxt; csz_r <= csz_nxt;
    psz_r <= psz_nxt; nsz_r <= nsz_nxt; pa_r <= pa_nxt; na_r <= na_nxt;
    gsz_r <= gsz_nxt; gbp_r <= gbp_nxt; pbp_r <= pbp_nxt;
    sbp_r <= sbp_nxt; ssz_r <= ssz_nxt; sa_r <= sa_nxt;
    res_r <= res_nxt; cfrom_r <= cfrom_nxt; cbytes_r <= cbytes_nxt; st_r <= st_nxt;
  end

endmodule

@@ design/next_fit_boundary_tag_allocator.sv @@
// Top level of the next-fit boundary-tag allocator: sequencer, tag RAM, output register.
// Depends on nfbta_pkg, nfbta_ram and nfbta_ctrl.
//
// One request at a time. A malloc reads one block header for each block visited by the
// next-fit walk, then places the block, splitting, growing and coalescing as needed.
// Realloc adds checks of the block address and can chain a malloc and a free. Each tag
// read or write is one access to the single tag RAM, whose read answers in the cycle
// after its address. The tag RAM is not cleared: init writes only the pad, prologue and
// epilogue tags and the tags of its first heap growth. A finished result waits in the
// output register while the next request is taken.
module next_fit_boundary_tag_allocator #(
  parameter int HEAP_BYTES = nfbta_pkg::HEAP_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [nfbta_pkg::FUNC_W-1:0] in_func,
  input  logic [nfbta_pkg::REQ_W-1:0]  in_req_bytes,
  input  logic [nfbta_pkg::ADDR_W-1:0] in_block_addr,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [nfbta_pkg::ADDR_W-1:0] out_result_addr,
  output logic [nfbta_pkg::STAT_W-1:0] out_status,
  output logic [nfbta_pkg::ADDR_W-1:0] out_copy_from,
  output logic [nfbta_pkg::REQ_W-1:0]  out_copy_bytes
);
  import nfbta_pkg::*;

  localparam int TAG_WORDS = HEAP_BYTES / 8;
  localparam int IW = $clog2(TAG_WORDS);

  nfbta_res_t      res;
  logic            res_ack;
  logic            ram_we, ram_re;
  logic [IW-1:0]   ram_waddr, ram_raddr;
  logic [TAG_W-1:0] ram_wdata, ram_rdata;
  logic            out_valid_r, out_valid_nxt;
  nfbta_res_t      out_r;

  nfbta_ctrl #(
    .HEAP_BYTES(HEAP_BYTES),
    .IW(IW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_req_bytes(in_req_bytes),
    .in_block_addr(in_block_addr),
    .res(res),
    .res_ack(res_ack),
    .ram_we(ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re(ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  nfbta_ram #(
    .DATA_W(TAG_W),
    .DEPTH(TAG_WORDS)
  ) u_tag_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // output register: load when empty or being drained
  assign res_ack = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid && res_ack) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ack) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_result_addr = out_r.result_addr;
  assign out_status = out_r.status;
  assign out_copy_from = out_r.copy_from;
  assign out_copy_bytes = out_r.copy_bytes;

  // reads and writes of the tag RAM never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("tag RAM read and write in the same cycle");

  // no request taken while a result is being handed off
  a_idle_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && res.valid))
    else $error("request taken while a result is pending");

  // a taken request leaves the sequencer busy
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sequencer idle right after a request");

  // a handed-off result shows on the output
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res_ack |=> out_valid)
    else $error("result lost at the output register");

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the next-fit boundary-tag allocator.
// Needs nfbta_pkg and next_fit_boundary_tag_allocator; carries its own heap model.
`timescale 1ns / 1ps

module tb_top;
  import nfbta_pkg::*;

  localparam longint unsigned HEAP_SZ = 1048576;
  localparam longint unsigned WORDS = HEAP_SZ / 8;
  localparam int N_RANDOM = 580;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [STAT_W-1:0] stat;
    logic [ADDR_W-1:0] cfrom;
    logic [REQ_W-1:0]  cbytes;
  } alloc_res_t;

  typedef struct {
    logic [FUNC_W-1:0] fn;
    int unsigned       req;
    int unsigned       addr;
    bit                use_last;
    bit                typed;
    logic [STAT_W-1:0] stat;
  } dir_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [FUNC_W-1:0] in_func = '0;
  logic [REQ_W-1:0] in_req_bytes = '0;
  logic [ADDR_W-1:0] in_block_addr = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [ADDR_W-1:0] out_result_addr;
  logic [STAT_W-1:0] out_status;
  logic [ADDR_W-1:0] out_copy_from;
  logic [REQ_W-1:0] out_copy_bytes;

  next_fit_boundary_tag_allocator uut (.*);

  // heap model state
  logic [63:0] tag_words [longint unsigned];
  longint unsigned heap_brk, rover_pos, first_blk;
  bit heap_ready;
  int unsigned live_q[$];
  longint unsigned last_ptr;

  alloc_res_t predicted_q[$];
  int err_cnt = 0;
  bit calm = 0;
  bit long_hold = 0;
  int n_moves = 0, n_oom = 0, n_ok_alloc = 0, n_results = 0;
  longint cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------- heap model ----------------
  function automatic longint unsigned rd(longint unsigned off);
    longint unsigned i = off >> 3;
    if (i < WORDS && tag_words.exists(i)) return tag_words[i];
    return 0;
  endfunction

  function automatic void wr(longint unsigned off, longint unsigned v);
    longint unsigned i = off >> 3;
    if (i < WORDS) tag_words[i] = v;
  endfunction

  function automatic longint unsigned tsz(longint unsigned off);
    return rd(off) & ~64'hF;
  endfunction

  function automatic longint unsigned tal(longint unsigned off);
    return rd(off) & 64'h1;
  endfunction

  function automatic longint unsigned bsz(longint unsigned bp);
    return tsz(bp - 8);
  endfunction

  function automatic void set_blk(longint unsigned bp, longint unsigned sz, longint unsigned a);
    wr(bp - 8, sz | a);
    wr(bp + sz - 16, sz | a);
  endfunction

  function automatic longint unsigned round16(longint unsigned x);
    return (x + 15) & ~64'hF;
  endfunction

  function automatic longint unsigned block_need(longint unsigned r);
    longint unsigned a = round16(r + 16);
    return (a < MIN_BLOCK) ? MIN_BLOCK : a;
  endfunction

  function automatic longint unsigned merge_free(longint unsigned bp);
    longint unsigned sz = bsz(bp);
    longint unsigned pa = tal(bp - 16);
    longint unsigned na = tal(bp + sz - 8);
    longint unsigned prv;
    if (pa && na) return bp;
    if (pa) begin
      sz += tsz(bp + sz - 8);
      set_blk(bp, sz, 0);
      return bp;
    end
    prv = bp - tsz(bp - 16);
    sz += bsz(prv);
    if (!na) sz += tsz(bp + bsz(bp) - 8);
    set_blk(prv, sz, 0);
    return prv;
  endfunction

  function automatic longint unsigned heap_grow(longint unsigned bytes);
    longint unsigned sz = round16(bytes);
    longint unsigned bp = heap_brk;
    if (heap_brk + sz > HEAP_SZ) return 0;
    heap_brk += sz;
    set_blk(bp, sz, 0);
    wr(bp + sz - 8, 1);
    return merge_free(bp);
  endfunction

  function automatic void carve(longint unsigned bp, longint unsigned asz);
    longint unsigned csz = bsz(bp);
    if (csz >= asz + MIN_BLOCK) begin
      set_blk(bp, asz, 1);
      set_blk(bp + asz, csz - asz, 0);
    end else begin
      set_blk(bp, csz, 1);
    end
  endfunction

  function automatic longint unsigned next_fit(longint unsigned asz);
    longint unsigned start = rover_pos, bp, s;
    for (bp = start; bp < heap_brk; bp += s) begin
      s = bsz(bp);
      if (s == 0) break;
      if (!tal(bp - 8) && s >= asz) begin
        rover_pos = bp;
        return bp;
      end
    end
    for (bp = first_blk; bp < start && bp < heap_brk; bp += s) begin
      s = bsz(bp);
      if (s == 0) break;
      if (!tal(bp - 8) && s >= asz) begin
        rover_pos = bp;
        return bp;
      end
    end
    return 0;
  endfunction

  function automatic longint unsigned heap_malloc(longint unsigned r, output longint unsigned st);
    longint unsigned asz, bp;
    if (r == 0) begin
      st = STAT_NULL;
      return 0;
    end
    asz = block_need(r);
    bp = next_fit(asz);
    if (bp == 0) begin
      bp = heap_grow(asz > GROW_MIN ? asz : GROW_MIN);
      if (bp == 0) begin
        st = STAT_OOM;
        return 0;
      end
    end
    carve(bp, asz);
    st = STAT_OK;
    return bp;
  endfunction

  function automatic void heap_free(longint unsigned bp);
    set_blk(bp, bsz(bp), 0);
    rover_pos = merge_free(bp);
  endfunction

  function automatic bit blk_ok(longint unsigned bp);
    longint unsigned h, s;
    if ((bp & 15) != 0 || bp < 32 || bp >= heap_brk) return 0;
    h = rd(bp - 8);
    s = h & ~64'hF;
    if (!(h & 1) || s < MIN_BLOCK || bp + s > heap_brk) return 0;
    return rd(bp + s - 16) == h;
  endfunction

  function automatic int live_idx(longint unsigned bp);
    foreach (live_q[i]) if (live_q[i] == bp) return i;
    return -1;
  endfunction

  function automatic void live_drop(longint unsigned bp);
    int i = live_idx(bp);
    if (i >= 0) live_q.delete(i);
  endfunction

  function automatic void live_add(longint unsigned bp);
    if (bp != 0) begin
      live_q.push_back(32'(bp));
      last_ptr = bp;
    end
  endfunction

  // an address is usable when its checks touch only written tags, and a pass means a live block
  function automatic bit addr_usable(longint unsigned bp);
    longint unsigned h, s;
    if (bp == 0 || (bp & 15) != 0 || bp < 32 || bp >= heap_brk) return 1;
    if (!tag_words.exists((bp - 8) >> 3)) return 0;
    h = rd(bp - 8);
    s = h & ~64'hF;
    if (!(h & 1) || s < MIN_BLOCK || bp + s > heap_brk) return 1;
    if (!tag_words.exists((bp + s - 16) >> 3)) return 0;
    if (rd(bp + s - 16) == h) return live_idx(bp) >= 0;
    return 1;
  endfunction

  function automatic alloc_res_t heap_predict(logic [FUNC_W-1:0] fn, longint unsigned r,
                                              longint unsigned ptr);
    longint unsigned res = 0, st = 0, cf = 0, cb = 0;
    longint unsigned asz, oldsz, nxt, nsz, total, need;
    bit done;
    alloc_res_t o;
    if (fn == FN_INIT) begin
      heap_brk = 0;
      wr(0, 0);
      wr(8, 17);
      wr(16, 17);
      wr(24, 1);
      heap_brk = 32;
      first_blk = 16;
      rover_pos = 16;
      live_q.delete();
      heap_ready = heap_grow(GROW_MIN) != 0;
      st = heap_ready ? STAT_OK : STAT_OOM;
    end else if (!heap_ready) begin
      st = STAT_NOINIT;
    end else if (fn == FN_MALLOC) begin
      res = heap_malloc(r, st);
      live_add(res);
    end else if (fn == FN_FREE) begin
      if (ptr != 0 && blk_ok(ptr)) begin
        heap_free(ptr);
        live_drop(ptr);
      end
    end else if (ptr == 0) begin
      res = heap_malloc(r, st);
      live_add(res);
    end else if (!blk_ok(ptr)) begin
      st = STAT_OOM;
    end else if (r == 0) begin
      heap_free(ptr);
      live_drop(ptr);
      st = STAT_NULL;
    end else begin
      asz = block_need(r);
      oldsz = bsz(ptr);
      nxt = ptr + oldsz;
      nsz = bsz(nxt);
      done = 0;
      if (asz <= oldsz) begin
        if (oldsz - asz >= MIN_BLOCK) carve(ptr, asz);
        done = 1;
      end else if (!tal(nxt - 8)) begin
        total = oldsz + nsz;
        if (total >= asz) begin
          if (rover_pos == nxt) rover_pos = ptr;
          set_blk(ptr, total, 1);
          if (total - asz >= MIN_BLOCK) carve(ptr, asz);
          done = 1;
        end
      end else if (nsz == 0) begin
        need = asz - oldsz;
        if (heap_grow(need > GROW_MIN ? need : GROW_MIN) == nxt) begin
          total = oldsz + bsz(nxt);
          set_blk(ptr, total, 1);
          if (total - asz >= MIN_BLOCK) carve(ptr, asz);
          done = 1;
        end
      end
      if (done) begin
        res = ptr;
      end else begin
        res = heap_malloc(r, st);
        if (res != 0) begin
          cf = ptr;
          cb = oldsz - 16;
          if (r < cb) cb = r;
          heap_free(ptr);
          live_drop(ptr);
          live_add(res);
          n_moves++;
        end
      end
    end
    if (st == STAT_OOM) n_oom++;
    if (st == STAT_OK && res != 0) n_ok_alloc++;
    o.addr = res[ADDR_W-1:0];
    o.stat = st[STAT_W-1:0];
    o.cfrom = cf[ADDR_W-1:0];
    o.cbytes = cb[REQ_W-1:0];
    return o;
  endfunction

  // ---------------- request driver ----------------
  task automatic send_request(logic [FUNC_W-1:0] fn, int unsigned r, int unsigned a);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    in_func <= fn;
    in_req_bytes <= r[REQ_W-1:0];
    in_block_addr <= a[ADDR_W-1:0];
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic int unsigned pick_size();
    int k = $urandom_range(0, 99);
    if (k < 70) return $urandom_range(1, 256);
    if (k < 92) return $urandom_range(257, 9000);
    if (k < 96) return $urandom_range(0, 2097151);
    return 0;
  endfunction

  function automatic int unsigned pick_block();
    int k = $urandom_range(0, 99);
    if (live_q.size() != 0 && k < 85) return live_q[$urandom_range(0, live_q.size() - 1)];
    if (k < 90) return 0;
    return $urandom_range(0, 1048575);
  endfunction

  // response hold-off, with one long stall to back the block up
  initial begin
    out_ready <= 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    alloc_res_t e;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (predicted_q.size() == 0) begin
        $error("unexpected result addr=%0d status=%0d", out_result_addr, out_status);
        err_cnt++;
      end else begin
        e = predicted_q.pop_front();
        if (out_result_addr !== e.addr) begin
          $error("result_addr expected %0d got %0d", e.addr, out_result_addr);
          err_cnt++;
        end
        if (out_status !== e.stat) begin
          $error("status expected %0d got %0d", e.stat, out_status);
          err_cnt++;
        end
        if (out_copy_from !== e.cfrom) begin
          $error("copy_from expected %0d got %0d", e.cfrom, out_copy_from);
          err_cnt++;
        end
        if (out_copy_bytes !== e.cbytes) begin
          $error("copy_bytes expected %0d got %0d", e.cbytes, out_copy_bytes);
          err_cnt++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // directed rows, then random traffic
  initial begin
    dir_row_t rows[$];
    dir_row_t rw;
    alloc_res_t e;
    logic [FUNC_W-1:0] fn;
    int unsigned r, a;
    int k;
    heap_brk = 0;
    rover_pos = 0;
    first_blk = 0;
    heap_ready = 0;
    last_ptr = 0;
    rows = '{
      '{FN_MALLOC, 16, 0, 0, 1, STAT_NOINIT},
      '{FN_FREE, 0, 32, 0, 1, STAT_NOINIT},
      '{FN_REALLOC, 64, 32, 0, 1, STAT_NOINIT},
      '{FN_INIT, 0, 0, 0, 1, STAT_OK},
      '{FN_MALLOC, 0, 0, 0, 1, STAT_NULL},
      '{FN_MALLOC, 1, 0, 0, 0, STAT_OK},
      '{FN_MALLOC, 1048576, 0, 0, 1, STAT_OOM},
      '{FN_MALLOC, 2097151, 0, 0, 1, STAT_OOM},
      '{FN_FREE, 0, 0, 0, 1, STAT_OK},
      '{FN_FREE, 0, 8, 0, 1, STAT_OK},
      '{FN_FREE, 0, 17, 0, 1, STAT_OK},
      '{FN_REALLOC, 100, 0, 0, 0, STAT_OK},
      '{FN_REALLOC, 100, 16, 0, 1, STAT_OOM},
      '{FN_REALLOC, 100, 1048560, 0, 1, STAT_OOM},
      '{FN_REALLOC, 100, 33, 0, 1, STAT_OOM},
      '{FN_REALLOC, 8, 0, 1, 0, STAT_OK},
      '{FN_REALLOC, 500, 0, 1, 0, STAT_OK},
      '{FN_MALLOC, 4000, 0, 0, 0, STAT_OK},
      '{FN_MALLOC, 8000, 0, 0, 0, STAT_OK},
      '{FN_FREE, 0, 0, 1, 0, STAT_OK},
      '{FN_MALLOC, 48, 0, 0, 0, STAT_OK},
      '{FN_REALLOC, 0, 0, 1, 0, STAT_OK},
      '{FN_MALLOC, 1000, 0, 0, 0, STAT_OK},
      '{FN_REALLOC, 20000, 0, 1, 0, STAT_OK},
      '{FN_INIT, 0, 0, 0, 1, STAT_OK}
    };
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed part
    foreach (rows[i]) begin
      rw = rows[i];
      a = rw.use_last ? 32'(last_ptr) : rw.addr;
      if (!addr_usable(a)) a = 0;
      e = heap_predict(rw.fn, rw.req, a);
      if (rw.typed) begin
        e = '0;
        e.stat = rw.stat;
      end
      predicted_q.push_back(e);
      send_request(rw.fn, rw.req, a);
    end

    // random part
    for (k = 0; k < N_RANDOM; k++) begin
      if (k == 150) long_hold = 1;
      if (k == 350) begin
        in_valid <= 0;
        wait (predicted_q.size() == 0);
        @(posedge clk);
      end
      if (k >= N_RANDOM - 60) calm = 1;
      r = $urandom_range(0, 99);
      if (r < 2) fn = FN_INIT;
      else if (live_q.size() > 40 || r < 35) fn = FN_FREE;
      else if (r < 70) fn = FN_MALLOC;
      else fn = FN_REALLOC;
      r = pick_size();
      a = pick_block();
      if (!addr_usable(a)) a = 0;
      e = heap_predict(fn, r, a);
      predicted_q.push_back(e);
      send_request(fn, r, a);
    end
    in_valid <= 0;

    wait (predicted_q.size() == 0);
    repeat (300) @(posedge clk);
    $display("covered %0d results: %0d allocations, %0d moves on realloc, %0d out-of-memory",
             n_results, n_ok_alloc, n_moves, n_oom);
    if (err_cnt == 0 && predicted_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
